>>> design/brb_pkg.sv
// shared types and codes for the batched packet reorder buffer
package brb_pkg;

    localparam int CFG_W  = 9;
    localparam int BYTE_W = 8;
    localparam int ID_W   = 8;
    localparam int KIND_W = 2;

    localparam logic OP_TAKE = 1'b0;
    localparam logic OP_PULL = 1'b1;

    localparam logic [KIND_W-1:0] KIND_BYTE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LINE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_IDLE = 2'd2;

    localparam logic [1:0] REG_PACKET_COUNT = 2'd0;
    localparam logic [1:0] REG_BATCH_SIZE   = 2'd1;

    typedef struct packed {
        logic              op;
        logic [ID_W-1:0]   packet_id;
        logic              has_byte;
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } item_t;

    typedef struct packed {
        logic [CFG_W-1:0] packet_count;
        logic [CFG_W-1:0] batch_size;
        logic             batch_written;
    } cfg_t;

endpackage

>>> design/batched_packet_reorder_buffer.sv
// top level: configuration registers, input queue and execution back end
// a take beat reads its slot through the registered slot ram read before it is executed
// a pull gives an idle beat when nothing is ready, a line end once its batch is spent,
// else one payload byte, skipping released packets whose bytes are all sent
// a batch close walks the frontier over completed packets, reading each slot in turn
// after reset a clearing pass over every slot runs before any beat is executed
module batched_packet_reorder_buffer #(
    parameter int PACKETS   = 256,
    parameter int MAX_BYTES = 512
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [23:0]                 s_tdata,   // packet_id, has_byte, data_byte, zero pad
    input  logic                        s_tuser,   // func
    input  logic                        s_tlast,   // last_byte
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata,   // batch_number, out_packet, out_byte
    output logic [brb_pkg::KIND_W-1:0]  m_tuser,   // kind
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [brb_pkg::CFG_W-1:0]   cfg_data
);
    import brb_pkg::*;

    logic [CFG_W-1:0] packet_count_reg, packet_count_next;
    logic [CFG_W-1:0] batch_size_reg, batch_size_next;
    logic             cfg_wr;
    cfg_t             cfg;
    logic             q_valid;
    item_t            q_item;
    logic             q_pop;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_comb
    begin
        packet_count_next = packet_count_reg;
        batch_size_next   = batch_size_reg;
        if (cfg_wr && cfg_index == REG_PACKET_COUNT)
        begin
            packet_count_next = cfg_data;
        end
        if (cfg_wr && cfg_index == REG_BATCH_SIZE)
        begin
            batch_size_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packet_count_reg <= CFG_W'(256);
            batch_size_reg   <= CFG_W'(1);
        end
        else
        begin
            packet_count_reg <= packet_count_next;
            batch_size_reg   <= batch_size_next;
        end
    end

    always_comb
    begin
        cfg.packet_count  = packet_count_reg;
        cfg.batch_size    = batch_size_reg;
        cfg.batch_written = cfg_wr && (cfg_index == REG_BATCH_SIZE);
    end

    brb_front u_front (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
    );

    brb_back #(.PACKETS(PACKETS), .MAX_BYTES(MAX_BYTES)) u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

endmodule

>>> design/brb_ram.sv
// generic single write port ram with registered read
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/brb_front.sv
// input side: unpacks beats and holds them in a two entry queue
module brb_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [23:0]    s_tdata,   // packet_id, has_byte, data_byte, zero pad
    input  logic           s_tuser,   // func
    input  logic           s_tlast,
    output logic           q_valid,
    output brb_pkg::item_t q_item,
    input  logic           q_pop
);
    import brb_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    item_t      beat;
    logic       push;
    logic       pop;

    always_comb
    begin
        beat.op        = s_tuser;
        beat.packet_id = s_tdata[7:0];
        beat.has_byte  = s_tdata[8];
        beat.data_byte = s_tdata[16:9];
        beat.last_byte = s_tlast;
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= beat;
        end
    end

endmodule

>>> design/brb_back.sv
// execution side: slot store, batch release, pull sequencing and output stage
module brb_back #(
    parameter int PACKETS   = 256,
    parameter int MAX_BYTES = 512
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  brb_pkg::cfg_t                 cfg,
    input  logic                          q_valid,
    input  brb_pkg::item_t                q_item,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,
    output logic [brb_pkg::KIND_W-1:0]    m_tuser
);
    import brb_pkg::*;

    localparam int SW  = $clog2(PACKETS);
    localparam int FW  = $clog2(PACKETS + 1);
    localparam int CW  = (FW > CFG_W) ? FW : CFG_W;
    localparam int LW  = $clog2(MAX_BYTES + 1);
    localparam int AW  = $clog2(PACKETS * MAX_BYTES);
    localparam int DW  = $clog2(CW + 1);
    localparam int SLW = LW + 1;
    localparam logic [CW-1:0] PK = CW'(PACKETS);
    localparam logic [LW-1:0] MB = LW'(MAX_BYTES);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_TEX   = 4'd3;
    localparam logic [3:0] S_AISS  = 4'd4;
    localparam logic [3:0] S_ACHK  = 4'd5;
    localparam logic [3:0] S_PUSH  = 4'd6;
    localparam logic [3:0] S_PLOOP = 4'd7;
    localparam logic [3:0] S_PSCHK = 4'd8;
    localparam logic [3:0] S_PBY   = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic [SW-1:0]     clr_reg, clr_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     fr_reg, fr_next;
    logic [CW-1:0]     fill_reg, fill_next;
    logic [CW-1:0]     line_reg, line_next;
    logic [CW-1:0]     ep_reg, ep_next;
    logic [LW-1:0]     off_reg, off_next;
    logic [CFG_W-1:0]  res_reg, res_next;
    logic [CW-1:0]     sh_reg, sh_next;
    logic [DW-1:0]     step_reg, step_next;
    logic              pend_reg, pend_next;
    item_t             item_reg, item_next;
    logic              out_valid_reg, out_valid_next;
    logic [KIND_W-1:0] out_kind_reg, out_kind_next;
    logic [7:0]        out_bn_reg, out_bn_next;
    logic [7:0]        out_pk_reg, out_pk_next;
    logic [7:0]        out_by_reg, out_by_next;

    logic              slot_we, slot_re;
    logic [SW-1:0]     slot_wa, slot_ra;
    logic [SLW-1:0]    slot_wd, slot_rd;
    logic              pay_we, pay_re;
    logic [AW-1:0]     pay_wa, pay_ra;
    logic [7:0]        pay_rd;
    logic              fq_we, fq_re;
    logic [SW-1:0]     fq_wa, fq_ra;
    logic [FW-1:0]     fq_wd, fq_rd;

    logic [CW-1:0]     n_c, q_c, id_c, c1, tgt;
    logic [CFG_W:0]    r_inc, trial;
    logic [CFG_W-1:0]  r1;
    logic              closes, out_free, in_range;
    logic [LW-1:0]     cur_len;

    function automatic logic [AW-1:0] pay_addr(input logic [SW-1:0] s, input logic [LW-1:0] l);
        pay_addr = AW'(AW'(s) * AW'(MAX_BYTES)) + AW'(l);
    endfunction

    brb_ram #(.WIDTH(SLW), .DEPTH(PACKETS)) u_slot_ram (
        .clk(clk), .we(slot_we), .waddr(slot_wa), .wdata(slot_wd),
        .re(slot_re), .raddr(slot_ra), .rdata(slot_rd)
    );

    brb_ram #(.WIDTH(8), .DEPTH(PACKETS * MAX_BYTES)) u_pay_ram (
        .clk(clk), .we(pay_we), .waddr(pay_wa), .wdata(item_reg.data_byte),
        .re(pay_re), .raddr(pay_ra), .rdata(pay_rd)
    );

    brb_ram #(.WIDTH(FW), .DEPTH(PACKETS)) u_fq_ram (
        .clk(clk), .we(fq_we), .waddr(fq_wa), .wdata(fq_wd),
        .re(fq_re), .raddr(fq_ra), .rdata(fq_rd)
    );

    assign n_c      = CW'(cfg.packet_count);
    assign q_c      = CW'(cfg.batch_size);
    assign id_c     = CW'(q_item.packet_id);
    assign in_range = (id_c < n_c) && (id_c < PK);
    assign c1       = cnt_reg + CW'(1);
    assign r_inc    = (CFG_W+1)'(res_reg) + (CFG_W+1)'(1);
    assign r1       = (r_inc == (CFG_W+1)'(cfg.batch_size)) ? '0 : CFG_W'(r_inc);
    assign closes   = (q_c != '0) && (q_c <= n_c) &&
                      ((c1 == n_c) ||
                       ((r1 == '0) && ((CW+1)'(c1) + (CW+1)'(q_c) <= (CW+1)'(n_c))));
    assign out_free = !out_valid_reg || m_tready;
    assign tgt      = CW'(fq_rd);
    assign cur_len  = slot_rd[LW-1:0];
    assign trial    = {res_reg, sh_reg[CW-1]};

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cnt_next       = cnt_reg;
        fr_next        = fr_reg;
        fill_next      = fill_reg;
        line_next      = line_reg;
        ep_next        = ep_reg;
        off_next       = off_reg;
        res_next       = res_reg;
        sh_next        = sh_reg;
        step_next      = step_reg;
        pend_next      = pend_reg;
        item_next      = item_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_bn_next    = out_bn_reg;
        out_pk_next    = out_pk_reg;
        out_by_next    = out_by_reg;
        slot_we        = 1'b0;
        slot_wa        = SW'(item_reg.packet_id);
        slot_wd        = '0;
        slot_re        = 1'b0;
        slot_ra        = SW'(q_item.packet_id);
        pay_we         = 1'b0;
        pay_wa         = pay_addr(SW'(item_reg.packet_id), cur_len);
        pay_re         = 1'b0;
        pay_ra         = pay_addr(SW'(ep_reg), off_reg);
        fq_we          = 1'b0;
        fq_wa          = SW'(fill_reg);
        fq_wd          = FW'(fr_reg);
        fq_re          = 1'b0;
        fq_ra          = SW'(line_reg);
        q_pop          = 1'b0;

        unique case (state_reg)
            S_CLR:
            begin
                slot_we  = 1'b1;
                slot_wa  = clr_reg;
                clr_next = clr_reg + SW'(1);
                if (clr_reg == SW'(PACKETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (pend_reg)
                begin
                    pend_next  = 1'b0;
                    res_next   = '0;
                    sh_next    = cnt_reg;
                    step_next  = DW'(CW);
                    state_next = S_DIV;
                end
                else if (q_valid)
                begin
                    if (q_item.op == OP_TAKE)
                    begin
                        q_pop = 1'b1;
                        if (in_range)
                        begin
                            item_next  = q_item;
                            slot_re    = 1'b1;
                            state_next = S_TEX;
                        end
                    end
                    else if ((line_reg < fill_reg) && (line_reg < PK))
                    begin
                        q_pop      = 1'b1;
                        fq_re      = 1'b1;
                        state_next = S_PLOOP;
                    end
                    else if (out_free)
                    begin
                        q_pop          = 1'b1;
                        out_valid_next = 1'b1;
                        out_kind_next  = KIND_IDLE;
                        out_bn_next    = '0;
                        out_pk_next    = '0;
                        out_by_next    = '0;
                    end
                end
            end
            S_DIV:
            begin
                res_next  = (trial >= (CFG_W+1)'(cfg.batch_size)) ?
                            CFG_W'(trial - (CFG_W+1)'(cfg.batch_size)) : CFG_W'(trial);
                sh_next   = sh_reg << 1;
                step_next = step_reg - DW'(1);
                if (step_reg == DW'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_TEX:
            begin
                state_next = S_IDLE;
                if (!slot_rd[LW])
                begin
                    slot_we = 1'b1;
                    slot_wd = {item_reg.last_byte, cur_len};
                    if (item_reg.has_byte && (cur_len < MB))
                    begin
                        pay_we  = 1'b1;
                        slot_wd = {item_reg.last_byte, cur_len + LW'(1)};
                    end
                    if (item_reg.last_byte)
                    begin
                        cnt_next = c1;
                        res_next = r1;
                        if (closes)
                        begin
                            state_next = S_AISS;
                        end
                    end
                end
            end
            S_AISS:
            begin
                if ((fr_reg < n_c) && (fr_reg < PK))
                begin
                    slot_re    = 1'b1;
                    slot_ra    = SW'(fr_reg);
                    state_next = S_ACHK;
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end
            S_ACHK:
            begin
                if (slot_rd[LW])
                begin
                    fr_next    = fr_reg + CW'(1);
                    state_next = S_AISS;
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (fill_reg < PK)
                begin
                    fq_we     = 1'b1;
                    fill_next = fill_reg + CW'(1);
                end
                state_next = S_IDLE;
            end
            S_PLOOP:
            begin
                if ((ep_reg < tgt) && (ep_reg < PK))
                begin
                    slot_re    = 1'b1;
                    slot_ra    = SW'(ep_reg);
                    state_next = S_PSCHK;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_LINE;
                    out_bn_next    = line_reg[7:0];
                    out_pk_next    = '0;
                    out_by_next    = '0;
                    line_next      = line_reg + CW'(1);
                    state_next     = S_IDLE;
                end
            end
            S_PSCHK:
            begin
                if (off_reg < cur_len)
                begin
                    pay_re     = 1'b1;
                    state_next = S_PBY;
                end
                else
                begin
                    ep_next    = ep_reg + CW'(1);
                    off_next   = '0;
                    state_next = S_PLOOP;
                end
            end
            S_PBY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_BYTE;
                    out_bn_next    = line_reg[7:0];
                    out_pk_next    = ep_reg[7:0];
                    out_by_next    = pay_rd;
                    off_next       = off_reg + LW'(1);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg.batch_written)
        begin
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            fr_reg        <= '0;
            fill_reg      <= '0;
            line_reg      <= '0;
            ep_reg        <= '0;
            off_reg       <= '0;
            res_reg       <= '0;
            step_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            fr_reg        <= fr_next;
            fill_reg      <= fill_next;
            line_reg      <= line_next;
            ep_reg        <= ep_next;
            off_reg       <= off_next;
            res_reg       <= res_next;
            step_reg      <= step_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg       <= sh_next;
        item_reg     <= item_next;
        out_kind_reg <= out_kind_next;
        out_bn_reg   <= out_bn_next;
        out_pk_reg   <= out_pk_next;
        out_by_reg   <= out_by_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {out_by_reg, out_pk_reg, out_bn_reg};

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= PK)
        else $error("batch queue fill beyond capacity");

    a_line_bound: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg <= fill_reg)
        else $error("line counter passed recorded batches");

    a_clr_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR) |-> !q_pop)
        else $error("item taken during clearing pass");

    a_byte_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PBY && out_free) |=> (out_valid_reg && out_kind_reg == KIND_BYTE))
        else $error("payload beat not presented");

endmodule
